// ===== rtl/i2cmts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmts_pkg
// Shared types and constants for the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

	localparam int WRITE_DEPTH = 8;
	localparam int READ_DEPTH  = 32;

	localparam int WR_CNT_W = $clog2(WRITE_DEPTH + 1);
	localparam int RD_CNT_W = $clog2(READ_DEPTH + 1);
	localparam int WR_IDX_W = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_EVENT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ACT_NONE       = 3'd0,
		ACT_SEND       = 3'd1,
		ACT_RESTART    = 3'd2,
		ACT_RECV_ENTER = 3'd3,
		ACT_RECV_ACK   = 3'd4,
		ACT_RECV_NACK  = 3'd5,
		ACT_STOP       = 3'd6
	} act_t;

	typedef enum logic [1:0] {
		OUT_NONE    = 2'd0,
		OUT_SUCCESS = 2'd1,
		OUT_NOACK   = 2'd2
	} outcome_t;

	typedef struct packed {
		logic                accepted;
		act_t                bus_action;
		logic [7:0]          tx_byte;
		logic                read_valid;
		logic [4:0]          read_index;
		logic [7:0]          read_byte;
		logic                done_res;
		outcome_t            outcome;
		logic                busy_res;
	} rsp_t;

	typedef struct packed {
		logic                en;
		logic [WR_IDX_W-1:0] idx;
		logic [7:0]          data;
	} wbuf_wr_t;

endpackage

// ===== rtl/i2cmts_wbuf.sv =====
// ----------------------------------------------------------------------------
// i2cmts_wbuf
// Write byte buffer: one write port, one combinational read port.
// ----------------------------------------------------------------------------
module i2cmts_wbuf (
	input  logic                                clk,
	input  i2cmts_pkg::wbuf_wr_t                wr,
	input  logic [i2cmts_pkg::WR_IDX_W-1:0]     rd_idx,
	output logic [7:0]                          rd_data
);

	logic [7:0] store_q [i2cmts_pkg::WRITE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			store_q[wr.idx] <= wr.data;
		end
	end

	assign rd_data = store_q[rd_idx];

endmodule

// ===== rtl/i2cmts_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2cmts_ctrl
// Transaction state and per-request decision logic.
// ----------------------------------------------------------------------------
module i2cmts_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                take,
	input  logic [1:0]                          kind,
	input  logic [6:0]                          address,
	input  logic [3:0]                          write_count,
	input  logic [5:0]                          read_count,
	input  logic [2:0]                          write_slot,
	input  logic [7:0]                          write_byte,
	input  logic                                ack_missing,
	input  logic [7:0]                          received_byte,
	input  logic [7:0]                          wbuf_data,
	output logic [i2cmts_pkg::WR_IDX_W-1:0]     wbuf_idx,
	output i2cmts_pkg::wbuf_wr_t                wbuf_wr,
	output i2cmts_pkg::rsp_t                    rsp
);

	localparam int WCW = i2cmts_pkg::WR_CNT_W;
	localparam int RCW = i2cmts_pkg::RD_CNT_W;

	logic           busy_q, rphase_q, dummy_q;
	logic [6:0]     taddr_q;
	logic [WCW-1:0] wtotal_q, wcnt_q;
	logic [RCW-1:0] rtotal_q, rcnt_q;

	logic           busy_d, rphase_d, dummy_d;
	logic [6:0]     taddr_d;
	logic [WCW-1:0] wtotal_d, wcnt_d;
	logic [RCW-1:0] rtotal_d, rcnt_d;
	logic           finish;

	assign wbuf_idx = i2cmts_pkg::WR_IDX_W'(wcnt_q);

	always_comb begin
		busy_d   = busy_q;
		rphase_d = rphase_q;
		dummy_d  = dummy_q;
		taddr_d  = taddr_q;
		wtotal_d = wtotal_q;
		wcnt_d   = wcnt_q;
		rtotal_d = rtotal_q;
		rcnt_d   = rcnt_q;
		finish   = 1'b0;

		rsp            = '0;
		rsp.bus_action = i2cmts_pkg::ACT_NONE;
		rsp.outcome    = i2cmts_pkg::OUT_NONE;

		wbuf_wr.en   = 1'b0;
		wbuf_wr.idx  = i2cmts_pkg::WR_IDX_W'(write_slot);
		wbuf_wr.data = write_byte;

		unique case (kind)
			i2cmts_pkg::KIND_START: begin
				if (!busy_q) begin
					taddr_d  = address;
					wtotal_d = (32'(write_count) > i2cmts_pkg::WRITE_DEPTH) ?
						WCW'(i2cmts_pkg::WRITE_DEPTH) : WCW'(write_count);
					rtotal_d = (32'(read_count) > i2cmts_pkg::READ_DEPTH) ?
						RCW'(i2cmts_pkg::READ_DEPTH) : RCW'(read_count);
					wcnt_d   = '0;
					rcnt_d   = '0;
					dummy_d  = 1'b1;
					rphase_d = 1'b0;
					busy_d   = 1'b1;
					rsp.accepted   = 1'b1;
					rsp.bus_action = i2cmts_pkg::ACT_SEND;
					rsp.tx_byte    = {address, 1'b0};
				end
			end
			i2cmts_pkg::KIND_LOAD: begin
				wbuf_wr.en = 32'(write_slot) < i2cmts_pkg::WRITE_DEPTH;
			end
			i2cmts_pkg::KIND_EVENT: begin
				if (busy_q) begin
					if (!rphase_q) begin
						if (ack_missing) begin
							rsp.bus_action = i2cmts_pkg::ACT_STOP;
							rsp.done_res   = 1'b1;
							rsp.outcome    = i2cmts_pkg::OUT_NOACK;
							finish         = 1'b1;
						end else if (wcnt_q >= wtotal_q) begin
							if (rtotal_q == '0) begin
								rsp.bus_action = i2cmts_pkg::ACT_STOP;
								rsp.done_res   = 1'b1;
								rsp.outcome    = i2cmts_pkg::OUT_SUCCESS;
								finish         = 1'b1;
							end else begin
								rsp.bus_action = i2cmts_pkg::ACT_RESTART;
								rsp.tx_byte    = {taddr_q, 1'b1};
								rphase_d       = 1'b1;
							end
						end else begin
							rsp.bus_action = i2cmts_pkg::ACT_SEND;
							rsp.tx_byte    = wbuf_data;
							wcnt_d         = wcnt_q + WCW'(1);
						end
					end else if (dummy_q) begin
						if (ack_missing) begin
							rsp.bus_action = i2cmts_pkg::ACT_STOP;
							rsp.done_res   = 1'b1;
							rsp.outcome    = i2cmts_pkg::OUT_NOACK;
							finish         = 1'b1;
						end else begin
							rsp.bus_action = i2cmts_pkg::ACT_RECV_ENTER;
							dummy_d        = 1'b0;
							rcnt_d         = '0;
						end
					end else if (rcnt_q >= rtotal_q) begin
						rsp.bus_action = i2cmts_pkg::ACT_STOP;
						rsp.done_res   = 1'b1;
						rsp.outcome    = i2cmts_pkg::OUT_SUCCESS;
						finish         = 1'b1;
					end else begin
						rsp.bus_action = (rcnt_q + RCW'(1) == rtotal_q) ?
							i2cmts_pkg::ACT_RECV_NACK : i2cmts_pkg::ACT_RECV_ACK;
						rsp.read_valid = 1'b1;
						rsp.read_index = 5'(rcnt_q);
						rsp.read_byte  = received_byte;
						rcnt_d         = rcnt_q + RCW'(1);
					end
				end
			end
			default: begin
			end
		endcase

		if (finish) begin
			busy_d   = 1'b0;
			rphase_d = 1'b0;
			wcnt_d   = '0;
			rcnt_d   = '0;
			dummy_d  = 1'b1;
		end

		rsp.busy_res = busy_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			rphase_q <= 1'b0;
			dummy_q  <= 1'b1;
			taddr_q  <= '0;
			wtotal_q <= '0;
			wcnt_q   <= '0;
			rtotal_q <= '0;
			rcnt_q   <= '0;
		end else if (take) begin
			busy_q   <= busy_d;
			rphase_q <= rphase_d;
			dummy_q  <= dummy_d;
			taddr_q  <= taddr_d;
			wtotal_q <= wtotal_d;
			wcnt_q   <= wcnt_d;
			rtotal_q <= rtotal_d;
			rcnt_q   <= rcnt_d;
		end
	end

endmodule

// ===== rtl/i2cmts_obuf.sv =====
// ----------------------------------------------------------------------------
// i2cmts_obuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module i2cmts_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  i2cmts_pkg::rsp_t   push_data,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output i2cmts_pkg::rsp_t   out_data
);

	logic             main_vld_q, skid_vld_q;
	i2cmts_pkg::rsp_t main_q, skid_q;
	logic             pop;

	assign pop       = main_vld_q && !out_stall;
	assign full      = skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop || !main_vld_q) begin
			if (skid_vld_q) begin
				main_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				main_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !main_vld_q) begin
			main_q <= skid_vld_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ===== rtl/i2c_master_transaction_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Write-then-read I2C transaction sequencer above a byte-level I2C engine.
// ----------------------------------------------------------------------------
// Each request (start, load write byte, byte-complete event) is decided in
// the cycle it is accepted and gives exactly one response; a new request can
// be accepted every cycle while in_stall is low. Responses pass through a
// two-entry output buffer, so requests keep flowing while one response waits;
// in_stall rises only when both entries are held by a stalled output.
module i2c_master_transaction_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [6:0] address,
	input  logic [3:0] write_count,
	input  logic [5:0] read_count,
	input  logic [2:0] write_slot,
	input  logic [7:0] write_byte,
	input  logic       ack_missing,
	input  logic [7:0] received_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       accepted,
	output logic [2:0] bus_action,
	output logic [7:0] tx_byte,
	output logic       read_valid,
	output logic [4:0] read_index,
	output logic [7:0] read_byte,
	output logic       done_res,
	output logic [1:0] outcome,
	output logic       busy_res
);

	logic                                take;
	logic                                full;
	logic [i2cmts_pkg::WR_IDX_W-1:0]     wbuf_idx;
	logic [7:0]                          wbuf_data;
	i2cmts_pkg::wbuf_wr_t                wbuf_wr;
	i2cmts_pkg::wbuf_wr_t                wbuf_wr_raw;
	i2cmts_pkg::rsp_t                    rsp, rsp_out;

	assign in_stall = full;
	assign take     = in_valid && !full;

	i2cmts_wbuf u_wbuf (
		.clk     (clk),
		.wr      (wbuf_wr),
		.rd_idx  (wbuf_idx),
		.rd_data (wbuf_data)
	);

	i2cmts_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.kind          (kind),
		.address       (address),
		.write_count   (write_count),
		.read_count    (read_count),
		.write_slot    (write_slot),
		.write_byte    (write_byte),
		.ack_missing   (ack_missing),
		.received_byte (received_byte),
		.wbuf_data     (wbuf_data),
		.wbuf_idx      (wbuf_idx),
		.wbuf_wr       (wbuf_wr_raw),
		.rsp           (rsp)
	);

	always_comb begin
		wbuf_wr    = wbuf_wr_raw;
		wbuf_wr.en = wbuf_wr_raw.en && take;
	end

	i2cmts_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (rsp),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (rsp_out)
	);

	assign accepted   = rsp_out.accepted;
	assign bus_action = rsp_out.bus_action;
	assign tx_byte    = rsp_out.tx_byte;
	assign read_valid = rsp_out.read_valid;
	assign read_index = rsp_out.read_index;
	assign read_byte  = rsp_out.read_byte;
	assign done_res   = rsp_out.done_res;
	assign outcome    = rsp_out.outcome;
	assign busy_res   = rsp_out.busy_res;

endmodule

// ===== sim/tb_i2c_master_transaction_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_master_transaction_sequencer
// Self-checking bench for the write-then-read I2C transaction sequencer.
// ----------------------------------------------------------------------------
// Requests are driven through the valid/stall input in random bursts, and the
// response side stalls on its own pattern. A scoreboard keeps its own copy of
// the sequencer state, predicts one response per accepted request, and
// compares the responses field by field in order. A short directed sequence
// covers refused starts, count clamping, missing acknowledges in each phase
// and a full read. It is followed by random transactions, some of them cut
// short or aborted.
// ----------------------------------------------------------------------------
module tb_i2c_master_transaction_sequencer;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [6:0] RD_DUMMY    = 7'h7F;
	localparam int         IDLE_LIMIT  = 2000;
	localparam int         REQ_TARGET  = 1200;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] address;
		logic [3:0] write_count;
		logic [5:0] read_count;
		logic [2:0] write_slot;
		logic [7:0] write_byte;
		logic       ack_missing;
		logic [7:0] received_byte;
	} i2c_req_t;

	class seq_scoreboard;
		logic       busy;
		logic       in_read;
		logic [6:0] tgt_addr;
		logic [3:0] wr_total;
		logic [3:0] wr_done;
		logic [5:0] rd_total;
		logic [6:0] rd_done;
		logic [7:0] wr_buf [i2cmts_pkg::WRITE_DEPTH];
		i2cmts_pkg::rsp_t expected_q [$];
		int         errors;

		function new();
			busy     = 1'b0;
			in_read  = 1'b0;
			tgt_addr = '0;
			wr_total = '0;
			wr_done  = '0;
			rd_total = '0;
			rd_done  = RD_DUMMY;
			errors   = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void end_transaction();
			busy    = 1'b0;
			in_read = 1'b0;
			wr_done = '0;
			rd_done = RD_DUMMY;
		endfunction

		function void note_request(i2c_req_t r);
			i2cmts_pkg::rsp_t e;
			logic [3:0] wc;
			logic [5:0] rc;
			e  = '0;
			wc = r.write_count;
			rc = r.read_count;
			if (r.kind == i2cmts_pkg::KIND_START) begin
				if (!busy) begin
					if (wc > i2cmts_pkg::WRITE_DEPTH) wc = 4'(i2cmts_pkg::WRITE_DEPTH);
					if (rc > i2cmts_pkg::READ_DEPTH) rc = 6'(i2cmts_pkg::READ_DEPTH);
					tgt_addr     = r.address;
					wr_total     = wc;
					rd_total     = rc;
					wr_done      = '0;
					rd_done      = RD_DUMMY;
					in_read      = 1'b0;
					busy         = 1'b1;
					e.accepted   = 1'b1;
					e.bus_action = i2cmts_pkg::ACT_SEND;
					e.tx_byte    = {r.address, 1'b0};
				end
			end else if (r.kind == i2cmts_pkg::KIND_LOAD) begin
				if (r.write_slot < i2cmts_pkg::WRITE_DEPTH) wr_buf[r.write_slot] = r.write_byte;
			end else if (r.kind == i2cmts_pkg::KIND_EVENT && busy) begin
				if (!in_read) begin
					if (r.ack_missing) begin
						e.bus_action = i2cmts_pkg::ACT_STOP;
						e.done_res   = 1'b1;
						e.outcome    = i2cmts_pkg::OUT_NOACK;
						end_transaction();
					end else if (wr_done >= wr_total) begin
						if (rd_total == 0) begin
							e.bus_action = i2cmts_pkg::ACT_STOP;
							e.done_res   = 1'b1;
							e.outcome    = i2cmts_pkg::OUT_SUCCESS;
							end_transaction();
						end else begin
							e.bus_action = i2cmts_pkg::ACT_RESTART;
							e.tx_byte    = {tgt_addr, 1'b1};
							in_read      = 1'b1;
						end
					end else begin
						e.bus_action = i2cmts_pkg::ACT_SEND;
						e.tx_byte    = wr_buf[wr_done[2:0]];
						wr_done      = wr_done + 1'b1;
					end
				end else if (rd_done == RD_DUMMY) begin
					if (r.ack_missing) begin
						e.bus_action = i2cmts_pkg::ACT_STOP;
						e.done_res   = 1'b1;
						e.outcome    = i2cmts_pkg::OUT_NOACK;
						end_transaction();
					end else begin
						e.bus_action = i2cmts_pkg::ACT_RECV_ENTER;
						rd_done      = '0;
					end
				end else if (rd_done >= rd_total) begin
					e.bus_action = i2cmts_pkg::ACT_STOP;
					e.done_res   = 1'b1;
					e.outcome    = i2cmts_pkg::OUT_SUCCESS;
					end_transaction();
				end else begin
					e.bus_action = (rd_done + 1 == rd_total) ?
						i2cmts_pkg::ACT_RECV_NACK : i2cmts_pkg::ACT_RECV_ACK;
					e.read_valid = 1'b1;
					e.read_index = rd_done[4:0];
					e.read_byte  = r.received_byte;
					rd_done      = rd_done + 1'b1;
				end
			end
			e.busy_res = busy;
			expected_q.push_back(e);
		endfunction

		function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_response(i2cmts_pkg::rsp_t got);
			i2cmts_pkg::rsp_t e;
			if (expected_q.size() == 0) begin
				$error("response with no request pending");
				errors++;
				return;
			end
			e = expected_q.pop_front();
			cmp_field("accepted", 8'(e.accepted), 8'(got.accepted));
			cmp_field("bus_action", 8'(e.bus_action), 8'(got.bus_action));
			cmp_field("tx_byte", e.tx_byte, got.tx_byte);
			cmp_field("read_valid", 8'(e.read_valid), 8'(got.read_valid));
			cmp_field("read_index", 8'(e.read_index), 8'(got.read_index));
			cmp_field("read_byte", e.read_byte, got.read_byte);
			cmp_field("done_res", 8'(e.done_res), 8'(got.done_res));
			cmp_field("outcome", 8'(e.outcome), 8'(got.outcome));
			cmp_field("busy_res", 8'(e.busy_res), 8'(got.busy_res));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] kind = '0;
	logic [6:0] address = '0;
	logic [3:0] write_count = '0;
	logic [5:0] read_count = '0;
	logic [2:0] write_slot = '0;
	logic [7:0] write_byte = '0;
	logic       ack_missing = 1'b0;
	logic [7:0] received_byte = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       accepted;
	logic [2:0] bus_action;
	logic [7:0] tx_byte;
	logic       read_valid;
	logic [4:0] read_index;
	logic [7:0] read_byte;
	logic       done_res;
	logic [1:0] outcome;
	logic       busy_res;

	seq_scoreboard sb = new();
	int burst_left = 0;
	int req_sent = 0;
	int idle_cycles = 0;

	i2c_master_transaction_sequencer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.address(address),
		.write_count(write_count),
		.read_count(read_count),
		.write_slot(write_slot),
		.write_byte(write_byte),
		.ack_missing(ack_missing),
		.received_byte(received_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.bus_action(bus_action),
		.tx_byte(tx_byte),
		.read_valid(read_valid),
		.read_index(read_index),
		.read_byte(read_byte),
		.done_res(done_res),
		.outcome(outcome),
		.busy_res(busy_res)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// monitor: requests and responses observed at the same edge, request first
	always @(posedge clk) begin
		i2cmts_pkg::rsp_t got;
		logic hs;
		if (arst_n) begin
			hs = 1'b0;
			if (in_valid && !in_stall) begin
				sb.note_request(i2c_req_t'{kind, address, write_count, read_count,
					write_slot, write_byte, ack_missing, received_byte});
				hs = 1'b1;
			end
			if (out_valid && !out_stall) begin
				got.accepted   = accepted;
				got.bus_action = i2cmts_pkg::act_t'(bus_action);
				got.tx_byte    = tx_byte;
				got.read_valid = read_valid;
				got.read_index = read_index;
				got.read_byte  = read_byte;
				got.done_res   = done_res;
				got.outcome    = i2cmts_pkg::outcome_t'(outcome);
				got.busy_res   = busy_res;
				sb.check_response(got);
				hs = 1'b1;
			end
			idle_cycles = hs ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// response side: random stall modes plus a periodic long hold-off
	initial begin
		int cyc;
		int hold;
		int mode;
		int mode_left;
		cyc       = 0;
		hold      = 0;
		mode      = 0;
		mode_left = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 1500 == 700) hold = 150;
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 2);
					mode_left = $urandom_range(8, 64);
				end
				mode_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 1);
					default: out_stall <= (mode_left % 3 == 0);
				endcase
			end
		end
	end

	function automatic i2c_req_t random_req(logic [1:0] k);
		i2c_req_t r;
		r.kind          = k;
		r.address       = 7'($urandom);
		r.write_count   = 4'($urandom);
		r.read_count    = 6'($urandom);
		r.write_slot    = 3'($urandom);
		r.write_byte    = 8'($urandom);
		r.ack_missing   = 1'($urandom);
		r.received_byte = 8'($urandom);
		return r;
	endfunction

	task automatic push(input i2c_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid      <= 1'b1;
		kind          <= r.kind;
		address       <= r.address;
		write_count   <= r.write_count;
		read_count    <= r.read_count;
		write_slot    <= r.write_slot;
		write_byte    <= r.write_byte;
		ack_missing   <= r.ack_missing;
		received_byte <= r.received_byte;
		do @(posedge clk); while (in_stall);
		req_sent++;
	endtask

	task automatic do_start(input logic [6:0] a, input logic [3:0] wc, input logic [5:0] rc);
		i2c_req_t r;
		r             = random_req(i2cmts_pkg::KIND_START);
		r.address     = a;
		r.write_count = wc;
		r.read_count  = rc;
		push(r);
	endtask

	task automatic do_load(input logic [2:0] s, input logic [7:0] b);
		i2c_req_t r;
		r            = random_req(i2cmts_pkg::KIND_LOAD);
		r.write_slot = s;
		r.write_byte = b;
		push(r);
	endtask

	task automatic do_event(input logic nack, input logic [7:0] rb);
		i2c_req_t r;
		r               = random_req(i2cmts_pkg::KIND_EVENT);
		r.ack_missing   = nack;
		r.received_byte = rb;
		push(r);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic noise_item();
		case ($urandom_range(0, 2))
			0: push(random_req(KIND_UNUSED));
			1: do_start(7'($urandom), 4'($urandom), 6'($urandom));
			default: do_load(3'($urandom), 8'($urandom));
		endcase
	endtask

	task automatic directed_seq();
		// fill every write slot first so no unwritten entry is ever sent
		do_load(3'd0, 8'hFF);
		do_load(3'd1, 8'h00);
		do_load(3'd2, 8'hA5);
		do_load(3'd3, 8'h5A);
		do_load(3'd4, 8'h01);
		do_load(3'd5, 8'h80);
		do_load(3'd6, 8'h7F);
		do_load(3'd7, 8'hFE);
		do_event(1'b0, 8'h00);           // event while idle
		push(random_req(KIND_UNUSED));
		do_start(7'h00, 4'd0, 6'd0);
		do_start(7'h7F, 4'd3, 6'd3);     // refused while busy
		do_event(1'b0, 8'hFF);           // nothing to write or read: stop
		do_start(7'h7F, 4'd15, 6'd63);   // counts clamp
		do_event(1'b1, 8'h00);           // missing ack on address
		do_start(7'h55, 4'd1, 6'd1);
		do_load(3'd0, 8'h3C);            // load while busy still stores
		do_event(1'b0, 8'h00);
		do_event(1'b0, 8'h00);           // repeated start
		do_event(1'b1, 8'h00);           // missing ack on read address
		do_start(7'h2A, 4'd0, 6'd2);
		do_event(1'b0, 8'h11);
		do_event(1'b0, 8'h22);
		do_event(1'b1, 8'h00);           // receive with ack, ack_missing ignored
		do_event(1'b1, 8'hFF);           // last byte: receive with nack
		do_event(1'b1, 8'h33);           // stop, success
	endtask

	task automatic random_transaction();
		int wc;
		int rc;
		int n_ev;
		int abort_span;
		repeat ($urandom_range(0, 3)) do_load(3'($urandom), 8'($urandom));
		wc = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
		rc = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
		do_start(7'($urandom), 4'(wc), 6'(rc));
		if (wc > i2cmts_pkg::WRITE_DEPTH) wc = i2cmts_pkg::WRITE_DEPTH;
		if (rc > i2cmts_pkg::READ_DEPTH) rc = i2cmts_pkg::READ_DEPTH;
		n_ev       = wc + 1 + ((rc > 0) ? rc + 2 : 0);
		abort_span = wc + 1 + ((rc > 0) ? 1 : 0);
		if ($urandom_range(0, 9) == 0) n_ev = $urandom_range(0, n_ev);
		for (int i = 0; i < n_ev; i++) begin
			if ($urandom_range(0, 19) == 0) noise_item();
			if (i < abort_span) begin
				if ($urandom_range(0, 29) == 0) begin
					do_event(1'b1, 8'($urandom));
					break;
				end
				do_event(1'b0, 8'($urandom));
			end else begin
				do_event(1'($urandom_range(0, 1)), 8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_seq();
		wait_drained();
		while (req_sent < REQ_TARGET) begin
			random_transaction();
			if ($urandom_range(0, 14) == 0) wait_drained();
		end
		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
